// ===== rtl/wgsp_pkg.sv =====
// Shared types, codes and constants for the weighted graph shortest path engine.
// Used by the interfaces, the ALU, the top level and the checker; depends on nothing.
`default_nettype none

package wgsp_pkg;

  localparam int DEF_MAX_VERTICES = 64;
  localparam int DEF_MAX_DEGREE   = 16;
  localparam int DEF_WEIGHT_BITS  = 12;

  localparam int CMD_W  = 3;
  localparam int VTX_W  = 6;
  localparam int EW_W   = 12;
  localparam int STS_W  = 2;
  localparam int ANS_W  = 20;
  localparam int CFG_W  = 7;
  localparam int IND_W  = 11;
  localparam int DIST_W = 20;
  localparam int SUM_W  = 21;

  localparam logic [IND_W-1:0]  IND_MAX = 11'd2047;
  localparam logic [DIST_W-1:0] UNREACH = 20'd999999;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD    = 3'd0,
    CMD_REMOVE = 3'd1,
    CMD_EDGE   = 3'd2,
    CMD_DEGREE = 3'd3,
    CMD_COMMON = 3'd4,
    CMD_ALL    = 3'd5,
    CMD_DIST   = 3'd6
  } cmd_t;

  typedef enum logic [STS_W-1:0] {
    STS_OK     = 2'd0,
    STS_RANGE  = 2'd1,
    STS_FULL   = 2'd2,
    STS_NOEDGE = 2'd3
  } status_t;

  typedef enum logic {
    CFG_DIRECTED = 1'b0,
    CFG_VCOUNT   = 1'b1
  } cfg_idx_t;

  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_t;

  typedef struct packed {
    alu_op_t          op;
    logic [SUM_W-1:0] x;
    logic [SUM_W-1:0] y;
    logic [SUM_W-1:0] z;
  } alu_req_t;

  typedef struct packed {
    logic [SUM_W-1:0] res;
    logic             lt;
  } alu_rsp_t;

  typedef enum logic [5:0] {
    ST_IDLE, ST_DECODE, ST_EMIT,
    ST_DG_RD, ST_DG_ANS,
    ST_ADD_RA, ST_ADD_RB, ST_ADD_CHK, ST_ADD_RB2, ST_ADD_WB,
    ST_SC_LEN, ST_SC_LEN2, ST_SC_RD, ST_SC_CMP, ST_SC_DONE,
    ST_RM_MOVE, ST_RM_IND, ST_RM_INDW,
    ST_CN_LEN, ST_CN_LEN2, ST_CN_RD, ST_CN_GOT,
    ST_SP_INIT, ST_SP_SRC, ST_SP_POP, ST_SP_POP2, ST_SP_POP3,
    ST_SP_EDGE, ST_SP_NB, ST_SP_REL, ST_SP_ORD, ST_SP_OUT,
    ST_SP_ONE_RD, ST_SP_ONE
  } state_t;

endpackage

`default_nettype wire

// ===== rtl/wgsp_if.sv =====
// Valid/ready channel interfaces for command words and result words.
// Depends on wgsp_pkg for the field widths.
`default_nettype none

interface wgsp_in_if import wgsp_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] cmd;
  logic [VTX_W-1:0] vertex_a;
  logic [VTX_W-1:0] vertex_b;
  logic [EW_W-1:0]  edge_weight;
  logic             want_out_degree;

  modport source (output valid, cmd, vertex_a, vertex_b, edge_weight, want_out_degree,
                  input ready);
  modport sink (input valid, cmd, vertex_a, vertex_b, edge_weight, want_out_degree,
                output ready);
endinterface

interface wgsp_out_if import wgsp_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [STS_W-1:0] status;
  logic [ANS_W-1:0] answer;
  logic [VTX_W-1:0] result_vertex;
  logic             last;

  modport source (output valid, status, answer, result_vertex, last, input ready);
  modport sink (input valid, status, answer, result_vertex, last, output ready);
endinterface

`default_nettype wire

// ===== rtl/wgsp_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with registered data.
// Depends on nothing.
`default_nettype none

module wgsp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== rtl/wgsp_alu.sv =====
// Shared add/subtract and compare unit used for relaxation and degree counts.
// Depends on wgsp_pkg for the request and response types.
`default_nettype none

module wgsp_alu import wgsp_pkg::*; (
  input  wire alu_req_t req,
  output alu_rsp_t      rsp
);

  logic [SUM_W-1:0] res;

  always_comb begin
    unique case (req.op)
      ALU_ADD: res = req.x + req.y;
      ALU_SUB: res = req.x - req.y;
      default: res = req.x;
    endcase
    rsp.res = res;
    rsp.lt  = (res < req.z);
  end

endmodule

`default_nettype wire

// ===== rtl/weighted_graph_shortest_path_engine.sv =====
// Top level: command sequencer, adjacency, degree, distance and queue memories.
// Depends on wgsp_pkg, wgsp_if, wgsp_ram and wgsp_alu.
//
//   Port group   Dir   Handshake     Carries
//   in_ch        in    valid/ready   cmd, vertex_a, vertex_b, edge_weight, want_out_degree
//   out_ch       out   valid/ready   status, answer, result_vertex, last
//   cfg_*        in    cfg_we        cfg_index, cfg_wdata
//
// One word at a time. Degree reads the vertex info; add reads both info words, checks
// room and writes the entry (into both lists when undirected); edge test and remove walk
// the source list, and common neighbor walks the second list for each entry of the first.
// Distance commands set every distance to unreachable, then dequeue vertices and relax
// their edges through the single shared adder; the all-vertices command then gives one
// result per cycle while the output is not stalled. Reset is synchronous; there is no
// clearing pass. A full result register stalls the sequencer in its emit and distance output states.
`default_nettype none

module weighted_graph_shortest_path_engine import wgsp_pkg::*; #(
  parameter int MAX_VERTICES = DEF_MAX_VERTICES,
  parameter int MAX_DEGREE   = DEF_MAX_DEGREE,
  parameter int WEIGHT_BITS  = DEF_WEIGHT_BITS
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  wgsp_in_if.sink               in_ch,
  wgsp_out_if.source            out_ch,
  input  wire logic             cfg_we,
  input  wire logic             cfg_index,
  input  wire logic [CFG_W-1:0] cfg_wdata
);

  localparam int VW = $clog2(MAX_VERTICES);
  localparam int CW = $clog2(MAX_VERTICES + 1);
  localparam int SW = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;
  localparam int LW = $clog2(MAX_DEGREE + 1);
  localparam int WB = WEIGHT_BITS;
  localparam int AW = VW + SW;
  localparam int ADJ_DEPTH = MAX_VERTICES * (1 << SW);
  localparam int Q_DEPTH = 1 << VW;

  state_t            state_r, state_nxt;
  cmd_t              cmd_r, cmd_nxt;
  logic [VTX_W-1:0]  a_r, a_nxt, b_r, b_nxt;
  logic [WB-1:0]     w_r, w_nxt;
  logic              want_r, want_nxt;
  logic              directed_r, directed_nxt;
  logic [CW-1:0]     vcount_r, vcount_nxt;
  logic [MAX_VERTICES-1:0] vvalid_r, vvalid_nxt, qflag_r, qflag_nxt;
  logic              vi_vld_r, vi_vld_nxt;
  logic [VW-1:0]     sv_r, sv_nxt, tgt_r, tgt_nxt;
  logic              mw_r, mw_nxt, phase_r, phase_nxt, found_r, found_nxt;
  logic [LW-1:0]     idx_r, idx_nxt, len_r, len_nxt, oi_r, oi_nxt, olen_r, olen_nxt;
  logic [SW-1:0]     pos_r, pos_nxt;
  logic [IND_W-1:0]  ind_r, ind_nxt;
  logic [CW-1:0]     ii_r, ii_nxt, count_r, count_nxt;
  logic [VW-1:0]     head_r, head_nxt, now_r, now_nxt, nx_r, nx_nxt;
  logic [DIST_W-1:0] dnow_r, dnow_nxt;
  logic [WB-1:0]     wt_r, wt_nxt;
  status_t           rst_r, rst_nxt;
  logic [ANS_W-1:0]  rans_r, rans_nxt;
  logic [VTX_W-1:0]  rvx_r, rvx_nxt;
  logic              ov_r, ov_nxt, olast_r, olast_nxt;
  status_t           ost_r, ost_nxt;
  logic [ANS_W-1:0]  oans_r, oans_nxt;
  logic [VTX_W-1:0]  ovx_r, ovx_nxt;

  logic              adj_we;
  logic [AW-1:0]     adj_waddr, adj_raddr;
  logic [VW+WB-1:0]  adj_wdata, adj_rdata;
  logic              vi_we;
  logic [VW-1:0]     vi_waddr, vi_raddr;
  logic [LW+IND_W-1:0] vi_wdata, vi_rdata;
  logic              dist_we;
  logic [VW-1:0]     dist_waddr, dist_raddr;
  logic [DIST_W-1:0] dist_wdata, dist_rdata;
  logic              q_we;
  logic [VW-1:0]     q_waddr, q_raddr, q_wdata, q_rdata;
  alu_req_t          alu_req;
  alu_rsp_t          alu_rsp;

  logic [VW-1:0]     av, bv, adj_nb, tail;
  logic [WB-1:0]     adj_wt;
  logic [LW-1:0]     len_rd;
  logic [IND_W-1:0]  ind_rd;
  logic              a_ok, b_ok, slot_free;

  assign av      = VW'(a_r);
  assign bv      = VW'(b_r);
  assign adj_nb  = adj_rdata[VW+WB-1:WB];
  assign adj_wt  = adj_rdata[WB-1:0];
  assign len_rd  = vi_vld_r ? vi_rdata[LW+IND_W-1:IND_W] : '0;
  assign ind_rd  = vi_vld_r ? vi_rdata[IND_W-1:0] : '0;
  assign a_ok    = (32'(a_r) < 32'(vcount_r));
  assign b_ok    = (32'(b_r) < 32'(vcount_r));
  assign slot_free = !ov_r || out_ch.ready;
  assign tail    = head_r + VW'(count_r);

  assign in_ch.ready          = (state_r == ST_IDLE);
  assign out_ch.valid         = ov_r;
  assign out_ch.status        = ost_r;
  assign out_ch.answer        = oans_r;
  assign out_ch.result_vertex = ovx_r;
  assign out_ch.last          = olast_r;

  always_comb begin
    state_nxt = state_r;  cmd_nxt = cmd_r;  a_nxt = a_r;  b_nxt = b_r;  w_nxt = w_r;
    want_nxt = want_r;  directed_nxt = directed_r;  vcount_nxt = vcount_r;
    vvalid_nxt = vvalid_r;  qflag_nxt = qflag_r;
    sv_nxt = sv_r;  tgt_nxt = tgt_r;  mw_nxt = mw_r;  phase_nxt = phase_r;
    found_nxt = found_r;  idx_nxt = idx_r;  len_nxt = len_r;  oi_nxt = oi_r;
    olen_nxt = olen_r;  pos_nxt = pos_r;  ind_nxt = ind_r;  ii_nxt = ii_r;
    count_nxt = count_r;  head_nxt = head_r;  now_nxt = now_r;  nx_nxt = nx_r;
    dnow_nxt = dnow_r;  wt_nxt = wt_r;  rst_nxt = rst_r;  rans_nxt = rans_r;
    rvx_nxt = rvx_r;
    ov_nxt = ov_r && !out_ch.ready;
    ost_nxt = ost_r;  oans_nxt = oans_r;  ovx_nxt = ovx_r;  olast_nxt = olast_r;

    adj_we = 1'b0;  adj_waddr = '0;  adj_wdata = '0;  adj_raddr = '0;
    vi_we = 1'b0;  vi_waddr = '0;  vi_wdata = '0;  vi_raddr = '0;
    dist_we = 1'b0;  dist_waddr = '0;  dist_wdata = '0;  dist_raddr = '0;
    q_we = 1'b0;  q_waddr = '0;  q_wdata = '0;  q_raddr = '0;
    alu_req.op = ALU_ADD;  alu_req.x = '0;  alu_req.y = '0;  alu_req.z = '0;

    if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_DIRECTED: directed_nxt = cfg_wdata[0];
        CFG_VCOUNT: begin
          vcount_nxt = (32'(cfg_wdata) > MAX_VERTICES) ? CW'(MAX_VERTICES) : CW'(cfg_wdata);
          vvalid_nxt = '0;
          qflag_nxt  = '0;
        end
        default: directed_nxt = directed_r;
      endcase
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          cmd_nxt   = cmd_t'(in_ch.cmd);
          a_nxt     = in_ch.vertex_a;
          b_nxt     = in_ch.vertex_b;
          w_nxt     = WB'(in_ch.edge_weight);
          want_nxt  = in_ch.want_out_degree;
          state_nxt = ST_DECODE;
        end
      end
      ST_DECODE: begin
        rst_nxt  = STS_OK;
        rans_nxt = '0;
        rvx_nxt  = '0;
        unique case (cmd_r)
          CMD_DEGREE, CMD_ALL: begin
            if (!a_ok) begin
              rst_nxt   = STS_RANGE;
              state_nxt = ST_EMIT;
            end else if (cmd_r == CMD_DEGREE) begin
              state_nxt = ST_DG_RD;
            end else begin
              qflag_nxt = '0;
              ii_nxt    = '0;
              state_nxt = ST_SP_INIT;
            end
          end
          CMD_ADD, CMD_REMOVE, CMD_EDGE, CMD_COMMON, CMD_DIST: begin
            if (!a_ok || !b_ok) begin
              rst_nxt   = STS_RANGE;
              state_nxt = ST_EMIT;
            end else begin
              sv_nxt    = av;
              tgt_nxt   = bv;
              mw_nxt    = (cmd_r == CMD_REMOVE);
              phase_nxt = 1'b0;
              qflag_nxt = (cmd_r == CMD_DIST) ? '0 : qflag_r;
              ii_nxt    = '0;
              unique case (cmd_r)
                CMD_ADD:    state_nxt = ST_ADD_RA;
                CMD_COMMON: state_nxt = ST_CN_LEN;
                CMD_DIST:   state_nxt = ST_SP_INIT;
                default:    state_nxt = ST_SC_LEN;
              endcase
            end
          end
          default: state_nxt = ST_EMIT;
        endcase
      end
      ST_EMIT: begin
        if (slot_free) begin
          ov_nxt    = 1'b1;
          ost_nxt   = rst_r;
          oans_nxt  = rans_r;
          ovx_nxt   = rvx_r;
          olast_nxt = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_DG_RD: begin
        vi_raddr  = av;
        state_nxt = ST_DG_ANS;
      end
      ST_DG_ANS: begin
        rans_nxt  = (!directed_r || want_r) ? ANS_W'(len_rd) : ANS_W'(ind_rd);
        state_nxt = ST_EMIT;
      end
      ST_ADD_RA: begin
        vi_raddr  = av;
        state_nxt = ST_ADD_RB;
      end
      ST_ADD_RB: begin
        len_nxt   = len_rd;
        ind_nxt   = ind_rd;
        vi_raddr  = bv;
        state_nxt = ST_ADD_CHK;
      end
      ST_ADD_CHK: begin
        if ((directed_r && 32'(len_r) >= MAX_DEGREE) ||
            (!directed_r && a_r == b_r && 32'(len_r) + 2 > MAX_DEGREE) ||
            (!directed_r && a_r != b_r &&
             (32'(len_r) >= MAX_DEGREE || 32'(len_rd) >= MAX_DEGREE))) begin
          rst_nxt   = STS_FULL;
          state_nxt = ST_EMIT;
        end else begin
          adj_we    = 1'b1;
          adj_waddr = {av, len_r[SW-1:0]};
          adj_wdata = {bv, w_r};
          vi_we     = 1'b1;
          vi_waddr  = av;
          vi_wdata  = {LW'(len_r + 1'b1), ind_r};
          vvalid_nxt[av] = 1'b1;
          state_nxt = ST_ADD_RB2;
        end
      end
      ST_ADD_RB2: begin
        vi_raddr  = bv;
        state_nxt = ST_ADD_WB;
      end
      ST_ADD_WB: begin
        vi_we    = 1'b1;
        vi_waddr = bv;
        vvalid_nxt[bv] = 1'b1;
        if (directed_r) begin
          alu_req.op = ALU_ADD;
          alu_req.x  = SUM_W'(ind_rd);
          alu_req.y  = SUM_W'(1);
          alu_req.z  = SUM_W'(IND_MAX) + SUM_W'(1);
          vi_wdata   = {len_rd, alu_rsp.lt ? IND_W'(alu_rsp.res) : ind_rd};
        end else begin
          adj_we    = 1'b1;
          adj_waddr = {bv, len_rd[SW-1:0]};
          adj_wdata = {av, w_r};
          vi_wdata  = {LW'(len_rd + 1'b1), ind_rd};
        end
        state_nxt = ST_EMIT;
      end
      ST_SC_LEN: begin
        vi_raddr  = sv_r;
        state_nxt = ST_SC_LEN2;
      end
      ST_SC_LEN2: begin
        len_nxt   = len_rd;
        ind_nxt   = ind_rd;
        idx_nxt   = '0;
        found_nxt = 1'b0;
        state_nxt = ST_SC_RD;
      end
      ST_SC_RD: begin
        if (idx_r < len_r) begin
          adj_raddr = {sv_r, idx_r[SW-1:0]};
          state_nxt = ST_SC_CMP;
        end else begin
          state_nxt = ST_SC_DONE;
        end
      end
      ST_SC_CMP: begin
        idx_nxt   = LW'(idx_r + 1'b1);
        state_nxt = ST_SC_RD;
        if (adj_nb == tgt_r && (!mw_r || adj_wt == w_r)) begin
          found_nxt = 1'b1;
          pos_nxt   = idx_r[SW-1:0];
          if (!mw_r) begin
            state_nxt = ST_SC_DONE;
          end
        end
      end
      ST_SC_DONE: begin
        unique case (cmd_r)
          CMD_EDGE: begin
            rans_nxt  = ANS_W'(found_r);
            state_nxt = ST_EMIT;
          end
          CMD_COMMON: begin
            if (found_r) begin
              rans_nxt  = ANS_W'(1);
              state_nxt = ST_EMIT;
            end else begin
              oi_nxt    = LW'(oi_r + 1'b1);
              state_nxt = ST_CN_RD;
            end
          end
          CMD_REMOVE: begin
            if (!found_r) begin
              rst_nxt   = phase_r ? STS_OK : STS_NOEDGE;
              state_nxt = ST_EMIT;
            end else begin
              adj_raddr = {sv_r, SW'(len_r - 1'b1)};
              state_nxt = ST_RM_MOVE;
            end
          end
          default: state_nxt = ST_EMIT;
        endcase
      end
      ST_RM_MOVE: begin
        adj_we    = 1'b1;
        adj_waddr = {sv_r, pos_r};
        adj_wdata = adj_rdata;
        vi_we     = 1'b1;
        vi_waddr  = sv_r;
        vi_wdata  = {LW'(len_r - 1'b1), ind_r};
        vvalid_nxt[sv_r] = 1'b1;
        if (phase_r) begin
          state_nxt = ST_EMIT;
        end else if (directed_r) begin
          state_nxt = ST_RM_IND;
        end else begin
          sv_nxt    = bv;
          tgt_nxt   = av;
          phase_nxt = 1'b1;
          state_nxt = ST_SC_LEN;
        end
      end
      ST_RM_IND: begin
        vi_raddr  = bv;
        state_nxt = ST_RM_INDW;
      end
      ST_RM_INDW: begin
        alu_req.op = ALU_SUB;
        alu_req.x  = SUM_W'(ind_rd);
        alu_req.y  = SUM_W'(1);
        vi_we      = 1'b1;
        vi_waddr   = bv;
        vi_wdata   = {len_rd, (ind_rd != '0) ? IND_W'(alu_rsp.res) : ind_rd};
        vvalid_nxt[bv] = 1'b1;
        state_nxt  = ST_EMIT;
      end
      ST_CN_LEN: begin
        vi_raddr  = av;
        state_nxt = ST_CN_LEN2;
      end
      ST_CN_LEN2: begin
        olen_nxt  = len_rd;
        oi_nxt    = '0;
        state_nxt = ST_CN_RD;
      end
      ST_CN_RD: begin
        if (oi_r < olen_r) begin
          adj_raddr = {av, oi_r[SW-1:0]};
          state_nxt = ST_CN_GOT;
        end else begin
          state_nxt = ST_EMIT;
        end
      end
      ST_CN_GOT: begin
        tgt_nxt   = adj_nb;
        sv_nxt    = bv;
        mw_nxt    = 1'b0;
        state_nxt = ST_SC_LEN;
      end
      ST_SP_INIT: begin
        if (ii_r < vcount_r) begin
          dist_we    = 1'b1;
          dist_waddr = VW'(ii_r);
          dist_wdata = UNREACH;
          ii_nxt     = CW'(ii_r + 1'b1);
        end else begin
          state_nxt = ST_SP_SRC;
        end
      end
      ST_SP_SRC: begin
        dist_we    = 1'b1;
        dist_waddr = av;
        dist_wdata = '0;
        q_we       = 1'b1;
        q_waddr    = '0;
        q_wdata    = av;
        head_nxt   = '0;
        count_nxt  = CW'(1);
        qflag_nxt[av] = 1'b1;
        state_nxt  = ST_SP_POP;
      end
      ST_SP_POP: begin
        if (count_r == '0) begin
          ii_nxt    = '0;
          state_nxt = (cmd_r == CMD_ALL) ? ST_SP_ORD : ST_SP_ONE_RD;
        end else begin
          q_raddr   = head_r;
          state_nxt = ST_SP_POP2;
        end
      end
      ST_SP_POP2: begin
        now_nxt    = q_rdata;
        head_nxt   = VW'(head_r + 1'b1);
        count_nxt  = CW'(count_r - 1'b1);
        qflag_nxt[q_rdata] = 1'b0;
        dist_raddr = q_rdata;
        vi_raddr   = q_rdata;
        state_nxt  = ST_SP_POP3;
      end
      ST_SP_POP3: begin
        dnow_nxt  = dist_rdata;
        len_nxt   = len_rd;
        idx_nxt   = '0;
        state_nxt = ST_SP_EDGE;
      end
      ST_SP_EDGE: begin
        if (idx_r < len_r) begin
          adj_raddr = {now_r, idx_r[SW-1:0]};
          state_nxt = ST_SP_NB;
        end else begin
          state_nxt = ST_SP_POP;
        end
      end
      ST_SP_NB: begin
        nx_nxt     = adj_nb;
        wt_nxt     = adj_wt;
        dist_raddr = adj_nb;
        state_nxt  = ST_SP_REL;
      end
      ST_SP_REL: begin
        alu_req.op = ALU_ADD;
        alu_req.x  = SUM_W'(dnow_r);
        alu_req.y  = SUM_W'(wt_r);
        alu_req.z  = SUM_W'(dist_rdata);
        if (alu_rsp.lt) begin
          dist_we    = 1'b1;
          dist_waddr = nx_r;
          dist_wdata = DIST_W'(alu_rsp.res);
          if (!qflag_r[nx_r]) begin
            q_we      = 1'b1;
            q_waddr   = tail;
            q_wdata   = nx_r;
            count_nxt = CW'(count_r + 1'b1);
            qflag_nxt[nx_r] = 1'b1;
          end
        end
        idx_nxt   = LW'(idx_r + 1'b1);
        state_nxt = ST_SP_EDGE;
      end
      ST_SP_ORD: begin
        dist_raddr = VW'(ii_r);
        state_nxt  = ST_SP_OUT;
      end
      ST_SP_OUT: begin
        dist_raddr = VW'(ii_r);
        if (slot_free) begin
          ov_nxt     = 1'b1;
          ost_nxt    = STS_OK;
          oans_nxt   = ANS_W'(dist_rdata);
          ovx_nxt    = VTX_W'(ii_r);
          olast_nxt  = (32'(ii_r) + 1 == 32'(vcount_r));
          ii_nxt     = CW'(ii_r + 1'b1);
          dist_raddr = VW'(ii_r + 1'b1);
          if (32'(ii_r) + 1 == 32'(vcount_r)) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_SP_ONE_RD: begin
        dist_raddr = bv;
        state_nxt  = ST_SP_ONE;
      end
      ST_SP_ONE: begin
        rans_nxt  = ANS_W'(dist_rdata);
        rvx_nxt   = b_r;
        state_nxt = ST_EMIT;
      end
      default: state_nxt = ST_IDLE;
    endcase

    vi_vld_nxt = vvalid_r[vi_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      ov_r       <= 1'b0;
      directed_r <= 1'b0;
      vcount_r   <= '0;
      vvalid_r   <= '0;
      qflag_r    <= '0;
    end else begin
      state_r    <= state_nxt;
      ov_r       <= ov_nxt;
      directed_r <= directed_nxt;
      vcount_r   <= vcount_nxt;
      vvalid_r   <= vvalid_nxt;
      qflag_r    <= qflag_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;  a_r <= a_nxt;  b_r <= b_nxt;  w_r <= w_nxt;  want_r <= want_nxt;
    vi_vld_r <= vi_vld_nxt;  sv_r <= sv_nxt;  tgt_r <= tgt_nxt;  mw_r <= mw_nxt;
    phase_r <= phase_nxt;  found_r <= found_nxt;  idx_r <= idx_nxt;  len_r <= len_nxt;
    oi_r <= oi_nxt;  olen_r <= olen_nxt;  pos_r <= pos_nxt;  ind_r <= ind_nxt;
    ii_r <= ii_nxt;  count_r <= count_nxt;  head_r <= head_nxt;  now_r <= now_nxt;
    nx_r <= nx_nxt;  dnow_r <= dnow_nxt;  wt_r <= wt_nxt;  rst_r <= rst_nxt;
    rans_r <= rans_nxt;  rvx_r <= rvx_nxt;  ost_r <= ost_nxt;  oans_r <= oans_nxt;
    ovx_r <= ovx_nxt;  olast_r <= olast_nxt;
  end

  wgsp_ram #(.WIDTH(VW + WB), .DEPTH(ADJ_DEPTH)) u_adj_ram (
    .clk(clk), .we(adj_we), .waddr(adj_waddr), .wdata(adj_wdata),
    .raddr(adj_raddr), .rdata(adj_rdata)
  );

  wgsp_ram #(.WIDTH(LW + IND_W), .DEPTH(MAX_VERTICES)) u_info_ram (
    .clk(clk), .we(vi_we), .waddr(vi_waddr), .wdata(vi_wdata),
    .raddr(vi_raddr), .rdata(vi_rdata)
  );

  wgsp_ram #(.WIDTH(DIST_W), .DEPTH(MAX_VERTICES)) u_dist_ram (
    .clk(clk), .we(dist_we), .waddr(dist_waddr), .wdata(dist_wdata),
    .raddr(dist_raddr), .rdata(dist_rdata)
  );

  wgsp_ram #(.WIDTH(VW), .DEPTH(Q_DEPTH)) u_queue_ram (
    .clk(clk), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
    .raddr(q_raddr), .rdata(q_rdata)
  );

  wgsp_alu u_alu (
    .req(alu_req),
    .rsp(alu_rsp)
  );

endmodule

`default_nettype wire

// ===== rtl/wgsp_checker.sv =====
// Port-level assertions for the shortest path engine, bound to the top level.
// Depends on wgsp_pkg for field widths and the unreachable distance.
`default_nettype none

module wgsp_checker import wgsp_pkg::*; (
  input wire logic             clk,
  input wire logic             rst_n,
  input wire logic             in_valid,
  input wire logic             in_ready,
  input wire logic             out_valid,
  input wire logic             out_ready,
  input wire logic [STS_W-1:0] status,
  input wire logic [ANS_W-1:0] answer,
  input wire logic [VTX_W-1:0] result_vertex,
  input wire logic             last
);

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("accepted a word while still busy");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable({status, answer, result_vertex, last}))
    else $error("stalled result word changed");

  a_error_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status != STS_OK |-> answer == '0 && result_vertex == '0 && last)
    else $error("error result carries data");

  a_answer_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> answer <= ANS_W'(UNREACH))
    else $error("answer above unreachable mark");

  a_stream_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !last |-> !in_ready)
    else $error("ready during a distance stream");

endmodule

bind weighted_graph_shortest_path_engine wgsp_checker u_wgsp_checker (
  .clk(clk),
  .rst_n(rst_n),
  .in_valid(in_ch.valid),
  .in_ready(in_ch.ready),
  .out_valid(out_ch.valid),
  .out_ready(out_ch.ready),
  .status(out_ch.status),
  .answer(out_ch.answer),
  .result_vertex(out_ch.result_vertex),
  .last(out_ch.last)
);

`default_nettype wire
